[sv/gtkm_pkg.sv]
// Shared types and constants of the gamepad to key and mouse event block.
// Used by gtkm_ctrl, gtkm_dp and the top level; depends on nothing.
package gtkm_pkg;

	localparam int NUM_BUTTONS = 16;
	localparam int NUM_AXES = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int AXIS_SETUP_W = 34;
	localparam int MOUSE_CODE_LSB = 16;

	localparam logic [15:0] BUTTON_MASK = 16'((32'd1 << NUM_BUTTONS) - 32'd1);
	localparam logic [AXIS_SETUP_W-1:0] AXIS_SETUP_RESET = 34'h0_5000_6668;

	// Pending word vector: two slots per button (key, mouse button), then the move.
	localparam int EV_W = 33;
	localparam int EV_IDX_W = 6;
	localparam logic [EV_IDX_W-1:0] MOVE_SLOT = 6'd32;

	localparam int DIV_STEPS = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_CODES_LOW  = 3'd0,
		REG_KEY_CODES_HIGH = 3'd1,
		REG_KEY_ENABLE     = 3'd2,
		REG_MOUSE_MAP      = 3'd3,
		REG_AXIS_LX        = 3'd4,
		REG_AXIS_LY        = 3'd5,
		REG_AXIS_RX        = 3'd6,
		REG_AXIS_RY        = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_MOUSE = 2'd1,
		KIND_MOVE  = 2'd2
	} event_kind_t;

	localparam logic [1:0] MOUSE_RESERVED = 2'd3;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       div;
		logic       acc;
		logic       fin;
		logic       emit;
		logic [1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic ev_any;
		logic out_free;
	} dp_sts_t;

endpackage

[sv/gtkm_ctrl.sv]
// Sequencer of the gamepad to key and mouse event block.
// Steps the shared axis unit over the four axes, then drains the event vector.
// Depends on gtkm_pkg.
module gtkm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gtkm_pkg::dp_sts_t sts,
	output gtkm_pkg::dp_cmd_t cmd
);
	import gtkm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_ACC  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic [2:0] step_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.mul  = (state_q == ST_MUL);
		cmd.div  = (state_q == ST_DIV);
		cmd.acc  = (state_q == ST_ACC);
		cmd.fin  = (state_q == ST_FIN);
		cmd.emit = (state_q == ST_EMIT) && sts.ev_any && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						axis_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(DIV_STEPS - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'(NUM_AXES - 1)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// The last word leaves when the vector empties.
					if (!sts.ev_any) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/gtkm_dp.sv]
// Datapath of the gamepad to key and mouse event block: configuration registers,
// button change detection, axis multiply and divide unit, output register.
// Depends on gtkm_pkg.
module gtkm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [gtkm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gtkm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [15:0]                         button_bits,
	input  logic signed [15:0]                  left_x,
	input  logic signed [15:0]                  left_y,
	input  logic signed [15:0]                  right_x,
	input  logic signed [15:0]                  right_y,
	input  gtkm_pkg::dp_cmd_t                   cmd,
	output gtkm_pkg::dp_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          event_kind,
	output logic [7:0]                          key_code,
	output logic [1:0]                          mouse_button_code,
	output logic                                pressed,
	output logic signed [9:0]                   delta_x,
	output logic signed [9:0]                   delta_y,
	output logic                                last
);
	import gtkm_pkg::*;

	// Configuration.
	logic [63:0]             key_lo_q;
	logic [63:0]             key_hi_q;
	logic [15:0]             key_en_q;
	logic [47:0]             mouse_map_q;
	logic [AXIS_SETUP_W-1:0] axis_setup_q [NUM_AXES];

	// Sample state.
	logic [15:0]   last_btn_q;
	logic [15:0]   pr_q;
	logic [15:0]   axis_val_q [NUM_AXES];
	logic [EV_W-1:0] ev_q;

	// Axis unit.
	logic [31:0]       rem_q;
	logic [31:0]       dsh_q;
	logic [7:0]        quo_q;
	logic              neg_q;
	logic signed [9:0] dx_q;
	logic signed [9:0] dy_q;

	// Output register.
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        key_q;
	logic [1:0]        mcode_q;
	logic              pressed_q;
	logic signed [9:0] out_dx_q;
	logic signed [9:0] out_dy_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q    <= '0;
			key_hi_q    <= '0;
			key_en_q    <= '0;
			mouse_map_q <= '0;
			for (int k = 0; k < NUM_AXES; k++) begin
				axis_setup_q[k] <= AXIS_SETUP_RESET;
			end
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KEY_CODES_LOW:  key_lo_q <= cfg_data;
				REG_KEY_CODES_HIGH: key_hi_q <= cfg_data;
				REG_KEY_ENABLE:     key_en_q <= cfg_data[15:0];
				REG_MOUSE_MAP:      mouse_map_q <= cfg_data[47:0];
				REG_AXIS_LX:        axis_setup_q[0] <= cfg_data[AXIS_SETUP_W-1:0];
				REG_AXIS_LY:        axis_setup_q[1] <= cfg_data[AXIS_SETUP_W-1:0];
				REG_AXIS_RX:        axis_setup_q[2] <= cfg_data[AXIS_SETUP_W-1:0];
				REG_AXIS_RY:        axis_setup_q[3] <= cfg_data[AXIS_SETUP_W-1:0];
			endcase
		end
	end

	// Button change detection into the pending word vector.
	logic [15:0]     btn_cur;
	logic [15:0]     changed;
	logic [EV_W-1:0] ev_load;

	always_comb begin
		btn_cur = button_bits & BUTTON_MASK;
		changed = btn_cur ^ last_btn_q;
		ev_load = '0;
		for (int i = 0; i < 16; i++) begin
			ev_load[2*i]   = changed[i] & key_en_q[i];
			ev_load[2*i+1] = changed[i] & mouse_map_q[i]
				& (mouse_map_q[MOUSE_CODE_LSB + 2*i +: 2] != MOUSE_RESERVED);
		end
	end

	// Axis front end: magnitude, deadzone, sensitivity product.
	logic [15:0]             v;
	logic [AXIS_SETUP_W-1:0] setup;
	logic                    v_neg;
	logic [15:0]             v_negated;
	logic [14:0]             mag;
	logic [15:0]             a;
	logic [15:0]             dz;
	logic [15:0]             sens;
	logic [15:0]             diff;
	logic [16:0]             span;

	always_comb begin
		v         = axis_val_q[cmd.axis];
		setup     = axis_setup_q[cmd.axis];
		v_neg     = v[15];
		v_negated = 16'h0000 - v;
		// The most negative value is taken as full positive scale.
		if (v == 16'h8000) begin
			mag = 15'h7FFF;
		end else if (v_neg) begin
			mag = v_negated[14:0];
		end else begin
			mag = v[14:0];
		end
		a    = {mag, 1'b0};
		dz   = setup[17:2];
		sens = setup[33:18];
		diff = (setup[0] && (a > dz)) ? (a - dz) : 16'h0000;
		span = 17'h10000 - {1'b0, dz};
	end

	// Motion of the finished axis, signed.
	logic signed [9:0] motion;
	always_comb begin
		motion = signed'({2'b00, quo_q});
		if (neg_q) begin
			motion = -motion;
		end
	end

	// Lowest pending word.
	logic [EV_W-1:0]     ev_low;
	logic [EV_IDX_W-1:0] ev_idx;
	logic [3:0]          btn;
	logic [63:0]         key_word;
	logic [5:0]          mbase;

	always_comb begin
		ev_low = ev_q & (~ev_q + 33'd1);
		ev_idx = '0;
		for (int j = 0; j < EV_W; j++) begin
			if (ev_low[j]) begin
				ev_idx = ev_idx | EV_IDX_W'(j);
			end
		end
		btn      = ev_idx[4:1];
		key_word = btn[3] ? key_hi_q : key_lo_q;
		mbase    = 6'(MOUSE_CODE_LSB) + {1'b0, btn, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_btn_q  <= '0;
			ev_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_btn_q <= btn_cur;
				ev_q       <= ev_load;
			end else if (cmd.fin) begin
				ev_q[MOVE_SLOT] <= (dx_q != 10'sd0) || (dy_q != 10'sd0);
			end else if (cmd.emit) begin
				ev_q <= ev_q & ~ev_low;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pr_q          <= btn_cur;
			axis_val_q[0] <= left_x;
			axis_val_q[1] <= left_y;
			axis_val_q[2] <= right_x;
			axis_val_q[3] <= right_y;
			dx_q          <= '0;
			dy_q          <= '0;
		end
		if (cmd.mul) begin
			rem_q <= 32'(diff) * 32'(sens);
			// Divisor span * 256, prealigned for the top quotient bit.
			dsh_q <= {span, 15'h0000};
			quo_q <= '0;
			neg_q <= setup[1] ^ v_neg;
		end
		if (cmd.div) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				quo_q <= {quo_q[6:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.acc) begin
			if (cmd.axis[0]) begin
				dy_q <= dy_q + motion;
			end else begin
				dx_q <= dx_q + motion;
			end
		end
		if (cmd.emit) begin
			last_q    <= ((ev_q & ~ev_low) == '0);
			kind_q    <= KIND_KEY;
			key_q     <= '0;
			mcode_q   <= '0;
			pressed_q <= 1'b0;
			out_dx_q  <= '0;
			out_dy_q  <= '0;
			if (ev_idx == MOVE_SLOT) begin
				kind_q   <= KIND_MOVE;
				out_dx_q <= dx_q;
				out_dy_q <= dy_q;
			end else if (ev_idx[0]) begin
				kind_q    <= KIND_MOUSE;
				mcode_q   <= mouse_map_q[mbase +: 2];
				pressed_q <= pr_q[btn];
			end else begin
				key_q     <= key_word[{btn[2:0], 3'b000} +: 8];
				pressed_q <= pr_q[btn];
			end
		end
	end

	assign sts.ev_any   = |ev_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign event_kind        = kind_q;
	assign key_code          = key_q;
	assign mouse_button_code = mcode_q;
	assign pressed           = pressed_q;
	assign delta_x           = out_dx_q;
	assign delta_y           = out_dy_q;
	assign last              = last_q;

endmodule

[sv/gamepad_to_key_mouse_events.sv]
// Gamepad to key and mouse event block. After a sample word is accepted, the
// four stick axes pass one after another through a shared unit that takes each
// axis through one multiply, an eight-step restoring divide and one accumulate;
// the move word is then set in the pending vector and the event words leave, one
// event word per cycle while the consumer keeps out_ready high. Once the vector is
// empty the sequencer returns to idle, where the next sample word is accepted.
// Button events come first in ascending button order, key before mouse button,
// then the move word; last marks the final word of a sample, and a sample that
// causes nothing yields no word.
// Depends on gtkm_pkg, gtkm_ctrl and gtkm_dp.
module gamepad_to_key_mouse_events (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [gtkm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gtkm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      button_bits,
	input  logic signed [15:0]               left_x,
	input  logic signed [15:0]               left_y,
	input  logic signed [15:0]               right_x,
	input  logic signed [15:0]               right_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       event_kind,
	output logic [7:0]                       key_code,
	output logic [1:0]                       mouse_button_code,
	output logic                             pressed,
	output logic signed [9:0]                delta_x,
	output logic signed [9:0]                delta_y,
	output logic                             last
);
	import gtkm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gtkm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gtkm_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.button_bits       (button_bits),
		.left_x            (left_x),
		.left_y            (left_y),
		.right_x           (right_x),
		.right_y           (right_y),
		.cmd               (cmd),
		.sts               (sts),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.event_kind        (event_kind),
		.key_code          (key_code),
		.mouse_button_code (mouse_button_code),
		.pressed           (pressed),
		.delta_x           (delta_x),
		.delta_y           (delta_y),
		.last              (last)
	);

endmodule
